/* rtl/wbc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// wbc_pkg
// Shared types and constants for the workload boundness classifier.
// ---------------------------------------------------------------------------
package wbc_pkg;

  localparam int NUM_METRICS   = 4;
  localparam int NUM_MEDOIDS   = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TABLE_DEPTH   = 2 * NUM_METRICS + NUM_METRICS * NUM_MEDOIDS;
  localparam int TBL_AW        = 5;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int ACC_W         = 68;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_STRATEGY  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CPI_CPU   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BW_CPU    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CPI_MEM   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BW_MEM    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ROOF_INT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_ROOF_PEAK = 3'd6;

  // strategy codes
  localparam logic [1:0] STRAT_THRESH = 2'd0;
  localparam logic [1:0] STRAT_ROOF   = 2'd1;
  localparam logic [1:0] STRAT_MEDOID = 2'd2;

  // command codes
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  // work kind decided by the front end
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_DONE,
    KIND_ROOF,
    KIND_MEDOID
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic         cb;
    logic         mb;
    logic [4:0]   coef_index;
    logic [31:0]  coef_value;
    logic [31:0]  cpi;
    logic [31:0]  tpi;
    logic [31:0]  bw;
    logic [31:0]  fl;
    logic [12:0]  cpus;
  } item_t;

  typedef struct packed {
    logic [31:0] intensity;
    logic [31:0] peak;
  } roof_cfg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ROOF1,
    BK_ROOF2,
    BK_ROOF3,
    BK_OFF,
    BK_SCL,
    BK_DCPU,
    BK_DSCL,
    BK_MED,
    BK_ACC,
    BK_EMIT
  } bk_state_t;

  // table address of medoid k, metric i
  function automatic logic [TBL_AW-1:0] med_addr(input logic [1:0] k, input logic [1:0] i);
    med_addr = TBL_AW'(2 * NUM_METRICS) + TBL_AW'({k, 2'b00}) + TBL_AW'(i);
  endfunction

endpackage
`default_nettype wire

/* rtl/workload_boundness_classifier.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// workload_boundness_classifier
// Flags a performance sample as compute bound and/or memory bound.
// ---------------------------------------------------------------------------
// channel  | handshake           | payload
// in       | in_valid / in_stall | command, coef_*, metrics, cpu_count
// out      | out_valid/out_stall | cpu_limited, mem_limited
// cfg      | cfg_we              | cfg_index, cfg_data
//
// Front end takes one transfer per cycle while the queue has room.
// Back end: write and threshold items go straight to emit; roofline does one
// divide when compute bound, else three; medoid does a per-cpu divide and, for
// a nonzero scale, a scaled divide per metric, on the single bit-per-cycle
// divider. Reset is synchronous; the coefficient table is not cleared. A
// stalled result holds while the back end keeps working.
module workload_boundness_classifier import wbc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_command,
  input  wire logic [4:0]        in_coef_index,
  input  wire logic [31:0]       in_coef_value,
  input  wire logic [31:0]       in_cycles_per_instr,
  input  wire logic [31:0]       in_time_per_instr,
  input  wire logic [31:0]       in_mem_bandwidth,
  input  wire logic [31:0]       in_flop_rate,
  input  wire logic [12:0]       in_cpu_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_cpu_limited,
  output logic                   out_mem_limited
);

  logic      push;
  item_t     push_item;
  logic      pop;
  item_t     head;
  logic      q_full;
  logic      q_empty;
  roof_cfg_t roof_cfg;

  wbc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .q_full           (q_full),
    .command          (in_command),
    .coef_index       (in_coef_index),
    .coef_value       (in_coef_value),
    .cycles_per_instr (in_cycles_per_instr),
    .time_per_instr   (in_time_per_instr),
    .mem_bandwidth    (in_mem_bandwidth),
    .flop_rate        (in_flop_rate),
    .cpu_count        (in_cpu_count),
    .in_stall         (in_stall),
    .push             (push),
    .push_item        (push_item),
    .roof_cfg         (roof_cfg)
  );

  wbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  wbc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .roof_cfg        (roof_cfg),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cpu_limited (out_cpu_limited),
    .out_mem_limited (out_mem_limited)
  );

endmodule
`default_nettype wire

/* rtl/wbc_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// wbc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wbc_div #(
  parameter int NW = 49
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [31:0]   den,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [NW-1:0] quo_r;
  logic [31:0]   den_r;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // one trial subtract per cycle
  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

/* rtl/wbc_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// wbc_queue
// Short queue of classified items between front and back.
// ---------------------------------------------------------------------------
module wbc_queue import wbc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  assign head  = mem_r[rp_r];
  assign full  = cnt_r == (PW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;

endmodule
`default_nettype wire

/* rtl/wbc_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// wbc_front
// Configuration registers, input acceptance and rule selection.
// ---------------------------------------------------------------------------
module wbc_front import wbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_valid,
  input  wire logic              q_full,
  input  wire logic              command,
  input  wire logic [4:0]        coef_index,
  input  wire logic [31:0]       coef_value,
  input  wire logic [31:0]       cycles_per_instr,
  input  wire logic [31:0]       time_per_instr,
  input  wire logic [31:0]       mem_bandwidth,
  input  wire logic [31:0]       flop_rate,
  input  wire logic [12:0]       cpu_count,
  output logic                   in_stall,
  output logic                   push,
  output item_t                  push_item,
  output roof_cfg_t              roof_cfg
);

  logic [1:0]  strategy_r;
  logic [31:0] cpi_cpu_r;
  logic [31:0] bw_cpu_r;
  logic [31:0] cpi_mem_r;
  logic [31:0] bw_mem_r;
  logic [31:0] roof_int_r;
  logic [31:0] roof_peak_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r  <= STRAT_THRESH;
      cpi_cpu_r   <= 32'd29491;
      bw_cpu_r    <= 32'd16384000;
      cpi_mem_r   <= 32'd39322;
      bw_mem_r    <= 32'd22937600;
      roof_int_r  <= 32'd65536;
      roof_peak_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRATEGY:  strategy_r  <= cfg_data[1:0];
        REG_CPI_CPU:   cpi_cpu_r   <= cfg_data;
        REG_BW_CPU:    bw_cpu_r    <= cfg_data;
        REG_CPI_MEM:   cpi_mem_r   <= cfg_data;
        REG_BW_MEM:    bw_mem_r    <= cfg_data;
        REG_ROOF_INT:  roof_int_r  <= cfg_data;
        REG_ROOF_PEAK: roof_peak_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // transfer when the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify item, threshold rule resolved here
  always_comb begin
    push_item            = '0;
    push_item.coef_index = coef_index;
    push_item.coef_value = coef_value;
    push_item.cpi        = cycles_per_instr;
    push_item.tpi        = time_per_instr;
    push_item.bw         = mem_bandwidth;
    push_item.fl         = flop_rate;
    push_item.cpus       = (cpu_count == '0) ? 13'd1 : cpu_count;
    if (command == CMD_WRITE) begin
      push_item.kind = KIND_WRITE;
    end else if (strategy_r == STRAT_ROOF) begin
      push_item.kind = KIND_ROOF;
    end else if (strategy_r == STRAT_MEDOID) begin
      push_item.kind = KIND_MEDOID;
    end else begin
      push_item.kind = KIND_DONE;
      push_item.cb   = (cycles_per_instr < cpi_cpu_r) && (mem_bandwidth < bw_cpu_r);
      push_item.mb   = (cycles_per_instr > cpi_mem_r) && (mem_bandwidth > bw_mem_r);
    end
  end

  assign roof_cfg.intensity = roof_int_r;
  assign roof_cfg.peak      = roof_peak_r;

endmodule
`default_nettype wire

/* rtl/wbc_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// wbc_back
// Execution engine: table writes, roofline and nearest medoid rules.
// ---------------------------------------------------------------------------
module wbc_back import wbc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire item_t     head,
  input  wire logic      q_empty,
  input  wire roof_cfg_t roof_cfg,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic           out_cpu_limited,
  output logic           out_mem_limited
);

  localparam int NW = 33 + FRAC_BITS;
  localparam logic [31:0] ROOF_FRAC = 32'(((6 << FRAC_BITS) + 5) / 10);

  bk_state_t         state_r, state_nxt;
  item_t             ent_r;
  logic [31:0]       tbl [TABLE_DEPTH];
  logic [31:0]       rdata_r;
  logic [TBL_AW-1:0] raddr;
  logic [1:0]        midx_r;
  logic [1:0]        kidx_r;
  logic [31:0]       off_r;
  logic [31:0]       scl_r;
  logic              xneg_r;
  logic [31:0]       pt_r;
  logic [65:0]       sq_r;
  logic [ACC_W-1:0]  acc_r [NUM_MEDOIDS];
  logic              cb_r;
  logic              mb_r;
  logic              out_valid_r;
  logic              out_cb_r;
  logic              out_mb_r;

  logic              div_start;
  logic [NW-1:0]     div_num;
  logic [31:0]       div_den;
  logic              div_done;
  logic [NW-1:0]     div_quot;
  logic [31:0]       div_sat;
  logic [31:0]       metric;
  logic [33:0]       xval;
  logic [32:0]       xmag;
  logic [32:0]       sneg;
  logic [31:0]       smag;
  logic [32:0]       dval;
  logic [32:0]       dmag;
  logic              out_free;
  logic              qneg;

  wbc_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared datapath terms
  always_comb begin
    unique case (midx_r)
      2'd0:    metric = ent_r.cpi;
      2'd1:    metric = ent_r.tpi;
      2'd2:    metric = ent_r.bw;
      default: metric = ent_r.fl;
    endcase
    div_sat = (|div_quot[NW-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
    xval    = {2'b00, div_quot[31:0]} - {{2{off_r[31]}}, off_r};
    xmag    = xval[33] ? 33'(-xval) : xval[32:0];
    sneg    = 33'(-{scl_r[31], scl_r});
    smag    = scl_r[31] ? sneg[31:0] : scl_r;
    qneg    = xneg_r ^ scl_r[31];
    dval    = {pt_r[31], pt_r} - {rdata_r[31], rdata_r};
    dmag    = dval[32] ? 33'(-dval) : dval;
    out_free = !out_valid_r || !out_stall;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    raddr     = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_ROOF: begin
              div_start = 1'b1;
              div_num   = NW'({head.fl, {FRAC_BITS{1'b0}}});
              div_den   = head.bw;
              state_nxt = BK_ROOF1;
            end
            KIND_MEDOID: begin
              raddr     = TBL_AW'(NUM_METRICS);
              state_nxt = BK_OFF;
            end
            default: state_nxt = BK_EMIT;
          endcase
        end
      end
      BK_ROOF1: begin
        if (div_done) begin
          if (div_sat >= roof_cfg.intensity) begin
            state_nxt = BK_EMIT;
          end else begin
            div_start = 1'b1;
            div_num   = NW'(ent_r.bw);
            div_den   = {19'd0, ent_r.cpus};
            state_nxt = BK_ROOF2;
          end
        end
      end
      BK_ROOF2: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NW'({div_quot[31:0], {FRAC_BITS{1'b0}}});
          div_den   = roof_cfg.peak;
          state_nxt = BK_ROOF3;
        end
      end
      BK_ROOF3: begin
        if (div_done) state_nxt = BK_EMIT;
      end
      BK_OFF: begin
        // offset word arrives, scale read issued, per-cpu divide started
        raddr     = TBL_AW'(midx_r);
        div_start = 1'b1;
        div_num   = NW'(metric);
        div_den   = {19'd0, ent_r.cpus};
        state_nxt = BK_SCL;
      end
      BK_SCL: state_nxt = BK_DCPU;
      BK_DCPU: begin
        if (div_done) begin
          if (scl_r == '0) begin
            raddr     = med_addr(2'd0, midx_r);
            state_nxt = BK_MED;
          end else begin
            div_start = 1'b1;
            div_num   = {xmag, {FRAC_BITS{1'b0}}};
            div_den   = smag;
            state_nxt = BK_DSCL;
          end
        end
      end
      BK_DSCL: begin
        if (div_done) begin
          raddr     = med_addr(2'd0, midx_r);
          state_nxt = BK_MED;
        end
      end
      BK_MED: state_nxt = BK_ACC;
      BK_ACC: begin
        if (kidx_r != 2'(NUM_MEDOIDS - 1)) begin
          raddr     = med_addr(kidx_r + 2'd1, midx_r);
          state_nxt = BK_MED;
        end else if (midx_r != 2'(NUM_METRICS - 1)) begin
          raddr     = TBL_AW'(NUM_METRICS) + TBL_AW'(midx_r + 2'd1);
          state_nxt = BK_OFF;
        end else begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // coefficient table
  always_ff @(posedge clk) begin
    rdata_r <= tbl[raddr];
    if (state_r == BK_IDLE && pop && head.kind == KIND_WRITE &&
        head.coef_index < TBL_AW'(TABLE_DEPTH)) begin
      tbl[head.coef_index] <= head.coef_value;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        ent_r  <= head;
        cb_r   <= head.cb;
        mb_r   <= head.mb;
        midx_r <= '0;
        kidx_r <= '0;
        for (int k = 0; k < NUM_MEDOIDS; k++) acc_r[k] <= '0;
      end
      BK_ROOF1: begin
        if (div_done && div_sat >= roof_cfg.intensity) cb_r <= 1'b1;
      end
      BK_ROOF3: begin
        if (div_done) mb_r <= div_sat >= ROOF_FRAC;
      end
      BK_OFF: off_r <= rdata_r;
      BK_SCL: scl_r <= rdata_r;
      BK_DCPU: begin
        if (div_done) begin
          xneg_r <= xval[33];
          if (xval[33])       pt_r <= 32'h8000_0000;
          else if (xval != 0) pt_r <= 32'h7FFF_FFFF;
          else                pt_r <= '0;
        end
      end
      BK_DSCL: begin
        if (div_done) begin
          if (qneg) begin
            pt_r <= (div_quot > NW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                      : 32'(-div_quot[31:0]);
          end else begin
            pt_r <= (div_quot > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quot[31:0];
          end
        end
      end
      BK_MED: sq_r <= 66'(dmag) * 66'(dmag);
      BK_ACC: begin
        acc_r[kidx_r] <= acc_r[kidx_r] + ACC_W'(sq_r);
        if (kidx_r != 2'(NUM_MEDOIDS - 1)) begin
          kidx_r <= kidx_r + 2'd1;
        end else begin
          kidx_r <= '0;
          midx_r <= midx_r + 2'd1;
          if (midx_r == 2'(NUM_METRICS - 1)) begin
            // last medoid of last metric: sum for medoid two completes here
            cb_r <= (acc_r[0] < acc_r[1]) && (acc_r[0] < acc_r[2] + ACC_W'(sq_r));
            mb_r <= (acc_r[1] < acc_r[0]) && (acc_r[1] < acc_r[2] + ACC_W'(sq_r));
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == BK_EMIT && out_free) begin
      out_cb_r <= cb_r;
      out_mb_r <= mb_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cpu_limited = out_cb_r;
  assign out_mem_limited = out_mb_r;

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Workload boundness classifier testbench
// Drives samples and coefficient writes under random idling on both sides,
// predicts the compute/memory flags in fixed point and checks every result
// in order against the predicted flags.
// ---------------------------------------------------------------------------
module testbench;
  import wbc_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned ALL32 = 64'hFFFF_FFFF;
  localparam longint unsigned ROOF_FRAC = ((64'd6 << FRAC) + 64'd5) / 64'd10;
  localparam longint MAX_CYCLES = 64'd12_000_000;

  typedef struct packed {
    logic cb;
    logic mb;
  } flags_t;

  typedef struct {
    logic        command;
    logic [4:0]  coef_index;
    logic [31:0] coef_value;
    logic [31:0] cpi;
    logic [31:0] tpi;
    logic [31:0] bw;
    logic [31:0] fl;
    logic [12:0] cpus;
  } sample_t;

  // flag predictor with its own copy of registers and coefficient table
  class flag_scoreboard;
    logic [1:0]  strat;
    logic [31:0] lim[7];
    logic [31:0] coef[TABLE_DEPTH];
    flags_t      pending[$];
    int          mismatches;
    int          results;

    function new();
      strat = STRAT_THRESH;
      lim[REG_CPI_CPU] = 29491;
      lim[REG_BW_CPU] = 16384000;
      lim[REG_CPI_MEM] = 39322;
      lim[REG_BW_MEM] = 22937600;
      lim[REG_ROOF_INT] = 65536;
      lim[REG_ROOF_PEAK] = 65536;
      foreach (coef[i]) coef[i] = '0;
      mismatches = 0;
      results = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [31:0] v);
      if (idx == REG_STRATEGY) strat = v[1:0];
      else if (idx <= REG_ROOF_PEAK) lim[idx] = v;
    endfunction

    function longint unsigned udiv_sat(longint unsigned n, longint unsigned d);
      longint unsigned q;
      if (d == 0) return ALL32;
      q = n / d;
      return (q > ALL32) ? ALL32 : q;
    endfunction

    function longint norm_metric(longint unsigned m, longint unsigned c,
                                 logic [31:0] off, logic [31:0] scl);
      longint x;
      longint s;
      longint q;
      x = longint'(m / c) - longint'($signed(off));
      s = longint'($signed(scl));
      if (s == 0) return (x > 0) ? 64'sd2147483647 : ((x < 0) ? -64'sd2147483648 : 0);
      q = (x * (64'sd1 <<< FRAC)) / s;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_sample(sample_t s);
      flags_t f;
      longint unsigned c;
      longint unsigned q;
      longint unsigned raw[4];
      longint pt[4];
      logic [67:0] sqdist[3];
      longint d;
      f = '0;
      c = (s.cpus == 0) ? 1 : s.cpus;
      if (s.command == CMD_WRITE) begin
        if (s.coef_index < TABLE_DEPTH) coef[s.coef_index] = s.coef_value;
      end else if (strat == STRAT_ROOF) begin
        q = udiv_sat(longint'(s.fl) << FRAC, s.bw);
        if (q >= lim[REG_ROOF_INT]) f.cb = 1;
        else f.mb = udiv_sat((s.bw / c) << FRAC, lim[REG_ROOF_PEAK]) >= ROOF_FRAC;
      end else if (strat == STRAT_MEDOID) begin
        raw = '{s.cpi, s.tpi, s.bw, s.fl};
        for (int i = 0; i < NUM_METRICS; i++)
          pt[i] = norm_metric(raw[i], c, coef[NUM_METRICS + i], coef[i]);
        for (int k = 0; k < NUM_MEDOIDS; k++) begin
          sqdist[k] = '0;
          for (int i = 0; i < NUM_METRICS; i++) begin
            d = pt[i] - longint'($signed(coef[2 * NUM_METRICS + k * NUM_METRICS + i]));
            if (d < 0) d = -d;
            sqdist[k] += 68'(unsigned'(d) * unsigned'(d));
          end
        end
        f.cb = sqdist[0] < sqdist[1] && sqdist[0] < sqdist[2];
        f.mb = sqdist[1] < sqdist[0] && sqdist[1] < sqdist[2];
      end else begin
        f.cb = s.cpi < lim[REG_CPI_CPU] && s.bw < lim[REG_BW_CPU];
        f.mb = s.cpi > lim[REG_CPI_MEM] && s.bw > lim[REG_BW_MEM];
      end
      pending.push_back(f);
    endfunction

    function void check_result(flags_t got);
      flags_t want;
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result cb=%0b mb=%0b", got.cb, got.mb);
        return;
      end
      want = pending.pop_front();
      if (got.cb !== want.cb || got.mb !== want.mb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("flag mismatch at result %0d: expected cb=%0b mb=%0b, got cb=%0b mb=%0b",
                   results, want.cb, want.mb, got.cb, got.mb);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_command = 0;
  logic [4:0]  in_coef_index = '0;
  logic [31:0] in_coef_value = '0;
  logic [31:0] in_cycles_per_instr = '0;
  logic [31:0] in_time_per_instr = '0;
  logic [31:0] in_mem_bandwidth = '0;
  logic [31:0] in_flop_rate = '0;
  logic [12:0] in_cpu_count = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_cpu_limited;
  logic        out_mem_limited;

  flag_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  longint cycle_count = 0;
  int  sample_total = 0;
  bit  table_loaded = 0;

  workload_boundness_classifier u_top (.*);

  always #6 clk = ~clk;

  // receiver stall and result check
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{cb: out_cpu_limited, mb: out_mem_limited});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // one transfer, with random idle cycles before it
  task automatic send_item(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= s.command;
    in_coef_index <= s.coef_index;
    in_coef_value <= s.coef_value;
    in_cycles_per_instr <= s.cpi;
    in_time_per_instr <= s.tpi;
    in_mem_bandwidth <= s.bw;
    in_flop_rate <= s.fl;
    in_cpu_count <= s.cpus;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
    sample_total++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  // one register write, with the write enable dropped again before the task returns
  task automatic write_cfg(logic [CFG_AW-1:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_metric();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(65535);
      3: return $urandom_range(32'h0200_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t rand_sample(bit allow_write);
    sample_t s;
    s.command = allow_write && ($urandom_range(9) == 0) ? CMD_WRITE : CMD_CLASSIFY;
    s.coef_index = 5'($urandom_range(31));
    s.coef_value = $urandom;
    s.cpi = rand_metric();
    s.tpi = rand_metric();
    s.bw = rand_metric();
    s.fl = rand_metric();
    case ($urandom_range(3))
      0: s.cpus = '0;
      1: s.cpus = 13'($urandom_range(4096));
      2: s.cpus = 13'($urandom);
      default: s.cpus = 13'($urandom_range(1, 8));
    endcase
    return s;
  endfunction

  // fill every table word; small offsets and medoids keep the medoid metric meaningful
  task automatic load_table();
    sample_t s;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      s = rand_sample(0);
      s.command = CMD_WRITE;
      s.coef_index = 5'(i);
      if (i < NUM_METRICS) s.coef_value = ($urandom_range(7) == 0) ? 0 : $urandom;
      else if ($urandom_range(1)) s.coef_value = $signed($urandom_range(20000)) - 10000;
      else s.coef_value = $urandom;
      send_item(s);
    end
    table_loaded = 1;
  endtask

  task automatic random_config(int mode);
    write_cfg(REG_STRATEGY, (mode < 0) ? $urandom : mode);
    for (int r = REG_CPI_CPU; r <= REG_ROOF_PEAK; r++)
      case ($urandom_range(3))
        0: write_cfg(CFG_AW'(r), (r == REG_ROOF_PEAK) ? 1 : 0);
        1: write_cfg(CFG_AW'(r), 32'hFFFF_FFFF);
        2: write_cfg(CFG_AW'(r), $urandom_range(32'h0200_0000));
        default: write_cfg(CFG_AW'(r), $urandom);
      endcase
  endtask

  initial begin
    sample_t s;
    int phase_len;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset thresholds, field extremes, out-of-range write
    s = '{CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0};
    send_item(s);
    s.cpi = 20000; s.bw = 1000;
    send_item(s);
    s.cpi = 50000; s.bw = 32'h0200_0000; s.cpus = 4096;
    send_item(s);
    s = '{CMD_CLASSIFY, 5'h1F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF};
    send_item(s);
    s.command = CMD_WRITE;
    send_item(s);
    drain();
    // roofline: zero bandwidth, intensity edge, memory test
    write_cfg(REG_STRATEGY, STRAT_ROOF);
    s = '{CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0};
    send_item(s);
    s.bw = 65536; s.fl = 65536;
    send_item(s);
    s.fl = 65535; s.cpus = 1;
    send_item(s);
    s.bw = 32'hFFFF_FFFF; s.fl = 0; s.cpus = 4096;
    send_item(s);
    s.bw = 39322; s.cpus = 1;
    send_item(s);
    s.bw = 39321;
    send_item(s);
    drain();
    // medoid with the table filled, plus one threshold pass with strategy three
    write_cfg(REG_STRATEGY, STRAT_MEDOID);
    load_table();
    for (int i = 0; i < 6; i++) send_item(rand_sample(0));
    drain();
    write_cfg(REG_STRATEGY, 2'd3);
    for (int i = 0; i < 3; i++) send_item(rand_sample(0));
    drain();

    // random phases under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 35 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        random_config(sub == 3 ? -1 : sub % 3);
        if (sub == 2) load_table();
        phase_len = 140;
        for (int i = 0; i < phase_len; i++) send_item(rand_sample(1));
        // sender waits for all results before the next setting
        drain();
      end
    end

    // back to reset values for a final short pass
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(REG_STRATEGY, STRAT_THRESH);
    write_cfg(REG_CPI_CPU, 29491);
    write_cfg(REG_BW_CPU, 16384000);
    write_cfg(REG_CPI_MEM, 39322);
    write_cfg(REG_BW_MEM, 22937600);
    write_cfg(REG_ROOF_INT, 65536);
    write_cfg(REG_ROOF_PEAK, 65536);
    for (int i = 0; i < 40; i++) send_item(rand_sample(1));
    drain();

    $display("sent %0d items over threshold, roofline and medoid settings; %0d results",
             sample_total, sb.results);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* workload_boundness_classifier.f */
rtl/wbc_pkg.sv
rtl/wbc_div.sv
rtl/wbc_queue.sv
rtl/wbc_front.sv
rtl/wbc_back.sv
rtl/workload_boundness_classifier.sv
sim/testbench.sv
